// ----- design/hwppm_pkg.sv -----
// Package with the item types, register indexes and helpers of the path point matcher.
package hwppm_pkg;

  localparam int unsigned CfgDataBits = 20;
  localparam int unsigned CfgAddrBits = 2;
  localparam int unsigned HeadingBits = 17;
  localparam int unsigned PointHeadingBits = 16;
  localparam int unsigned CostBits = 32;
  localparam int unsigned DistBits = 31;
  localparam int unsigned WindowBits = 20;
  localparam int unsigned BackBits = 16;
  localparam int unsigned PenaltyBits = 16;
  localparam int unsigned FullTurn = 36000;
  localparam int unsigned HalfTurn = 18000;
  // The penalty of 25/9 mm per 0.01 degree is a multiply by 25 * 2^22 / 9, rounded up,
  // followed by a 22-bit shift; this is exact for every folded heading difference.
  localparam int unsigned PenaltyMult = 11650845;
  localparam int unsigned PenaltyShift = 22;

  typedef enum logic [CfgAddrBits-1:0] {
    REG_SEARCH_WINDOW = 2'd0,
    REG_ACCEPT_LIMIT  = 2'd1,
    REG_BACK_POINTS   = 2'd2
  } reg_index_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_SQRT,
    BK_DECIDE
  } back_state_t;

endpackage

// ----- design/hwppm_sqrt.sv -----
// Bit-serial integer square root, two radicand bits per cycle.
module hwppm_sqrt import hwppm_pkg::*; #(
  parameter int unsigned RadBits = 62
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic [RadBits-1:0]   radicand,
  output logic                 done,
  output logic [RadBits/2-1:0] root
);

  localparam int unsigned RootBits = RadBits / 2;
  localparam int unsigned CntBits = $clog2(RootBits + 1);

  logic [RootBits-1:0] rem;
  logic [RadBits-1:0]  src;
  logic [RootBits-1:0] acc;
  logic [CntBits-1:0]  count;
  logic                busy;
  logic [RootBits+1:0] trial;
  logic [RootBits+1:0] part;
  logic [RootBits+1:0] rest;
  logic                fits;

  always_comb begin
    part  = {rem, src[RadBits-1:RadBits-2]};
    trial = {acc, 2'b01};
    fits  = part >= trial;
    rest  = fits ? part - trial : part;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= busy && (count == CntBits'(1));
      if (start) begin
        busy  <= 1'b1;
        count <= CntBits'(RootBits);
        src   <= radicand;
        rem   <= '0;
        acc   <= '0;
      end else if (busy) begin
        src   <= {src[RadBits-3:0], 2'b00};
        rem   <= rest[RootBits-1:0];
        acc   <= {acc[RootBits-2:0], fits};
        count <= count - 1'b1;
        if (count == CntBits'(1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

  assign root = acc;

endmodule

// ----- design/hwppm_front.sv -----
// Front part: takes items, keeps the pose and start index, and queues start and point jobs.
module hwppm_front import hwppm_pkg::*; #(
  parameter int unsigned IndexBits = 16,
  parameter int unsigned CoordBits = 30
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        push,
  output logic                        full,
  input  logic                        action,
  input  logic signed [CoordBits-1:0] car_x,
  input  logic signed [CoordBits-1:0] car_y,
  input  logic signed [HeadingBits-1:0] car_heading,
  input  logic [IndexBits-1:0]        start_hint,
  input  logic                        restart_from_zero,
  input  logic signed [CoordBits-1:0] point_x,
  input  logic signed [CoordBits-1:0] point_y,
  input  logic [PointHeadingBits-1:0] point_heading,
  input  logic [IndexBits-1:0]        point_index,
  input  logic                        last_point,
  input  logic [BackBits-1:0]         back_points,
  input  logic                        job_take,
  output logic                        job_valid,
  output logic                        job_start,
  output logic                        job_last,
  output logic [CoordBits:0]          job_ax,
  output logic [CoordBits:0]          job_ay,
  output logic [PenaltyBits-1:0]      job_penalty,
  output logic [IndexBits-1:0]        job_index
);

  logic signed [CoordBits-1:0]   pose_x;
  logic signed [CoordBits-1:0]   pose_y;
  logic signed [HeadingBits-1:0] pose_heading;
  logic [IndexBits-1:0]          first_index;
  logic                          search_open;

  logic                          slot;
  logic                          emit;
  logic                          load;
  logic signed [CoordBits:0]     dx;
  logic signed [CoordBits:0]     dy;
  logic signed [HeadingBits+1:0] hd;
  logic [HeadingBits+1:0]        hmod;
  logic [HeadingBits+1:0]        hfold;
  logic [HeadingBits+25:0]       hprod;
  logic [IndexBits:0]            back_ext;
  logic [IndexBits:0]            diff;

  assign full = slot && !job_take;

  always_comb begin
    dx = $signed({point_x[CoordBits-1], point_x}) - $signed({pose_x[CoordBits-1], pose_x});
    dy = $signed({point_y[CoordBits-1], point_y}) - $signed({pose_y[CoordBits-1], pose_y});
    hd = $signed({3'b000, point_heading}) - $signed({{2{pose_heading[HeadingBits-1]}}, pose_heading})
         + (HeadingBits+2)'(FullTurn);
    hmod = hd[HeadingBits+1:0];
    if (hmod >= (HeadingBits+2)'(FullTurn)) begin
      hmod = hmod - (HeadingBits+2)'(FullTurn);
    end
    if (hmod >= (HeadingBits+2)'(FullTurn)) begin
      hmod = hmod - (HeadingBits+2)'(FullTurn);
    end
    hfold = (hmod > (HeadingBits+2)'(HalfTurn)) ? (HeadingBits+2)'(FullTurn) - hmod : hmod;
    hprod = (HeadingBits+26)'(hfold) * (HeadingBits+26)'(PenaltyMult);
    emit = push && !full && action && search_open &&
           (last_point || point_index >= first_index);
    load = (push && !full && !action) || emit;
    back_ext = (IndexBits+1)'(back_points);
    diff = {1'b0, start_hint} - back_ext;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slot         <= 1'b0;
      search_open  <= 1'b0;
      pose_x       <= '0;
      pose_y       <= '0;
      pose_heading <= '0;
      first_index  <= '0;
    end else begin
      if (load) begin
        slot <= 1'b1;
      end else if (job_take) begin
        slot <= 1'b0;
      end
      if (push && !full && !action) begin
        pose_x       <= car_x;
        pose_y       <= car_y;
        pose_heading <= car_heading;
        search_open  <= 1'b1;
        if (restart_from_zero || diff[IndexBits]) begin
          first_index <= '0;
        end else begin
          first_index <= diff[IndexBits-1:0];
        end
        job_start <= 1'b1;
        job_last  <= 1'b0;
      end else if (emit) begin
        job_start <= 1'b0;
        job_last  <= last_point;
        job_ax    <= dx[CoordBits] ? (CoordBits+1)'(-dx) : (CoordBits+1)'(dx);
        job_ay    <= dy[CoordBits] ? (CoordBits+1)'(-dy) : (CoordBits+1)'(dy);
        job_index <= point_index;
        if (pose_heading >= 0 && pose_heading <= $signed(HeadingBits'(FullTurn))) begin
          job_penalty <= PenaltyBits'(hprod >> PenaltyShift);
        end else begin
          job_penalty <= '0;
        end
        if (last_point) begin
          search_open <= 1'b0;
        end
      end
    end
  end

  assign job_valid = slot;

endmodule

// ----- design/hwppm_back.sv -----
// Back part: root of each point distance, best tracking, window logic and result queue.
module hwppm_back import hwppm_pkg::*; #(
  parameter int unsigned IndexBits = 16,
  parameter int unsigned CoordBits = 30
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   job_valid,
  output logic                   job_take,
  input  logic                   job_start,
  input  logic                   job_last,
  input  logic [CoordBits:0]     job_ax,
  input  logic [CoordBits:0]     job_ay,
  input  logic [PenaltyBits-1:0] job_penalty,
  input  logic [IndexBits-1:0]   job_index,
  input  logic [WindowBits-1:0]  search_window_mm,
  input  logic [WindowBits-1:0]  accept_limit_mm,
  input  logic                   pop,
  output logic                   empty,
  output logic                   found,
  output logic [IndexBits-1:0]   match_index,
  output logic [DistBits-1:0]    min_distance
);

  localparam int unsigned RadBits = 2 * CoordBits + 2;

  back_state_t                 state;
  back_state_t                 state_next;
  logic [CostBits-1:0]         best_cost;
  logic [DistBits-1:0]         best_distance;
  logic [IndexBits-1:0]        best_index;
  logic                        in_window;
  logic                        closed;
  logic [PenaltyBits-1:0]      penalty;
  logic [IndexBits-1:0]        index;
  logic [2*CoordBits+1:0]      sq_x;
  logic [2*CoordBits+1:0]      sq_y;
  logic                        sq_go;
  logic                        mul_go;
  logic                        sqrt_done;
  logic [RadBits/2-1:0]        root;
  logic [CostBits-1:0]         cost;
  logic                        out_full;
  logic                        take;
  logic                        improve;
  logic [CostBits-1:0]         new_best;
  logic                        win_now;
  logic                        leave;

  hwppm_sqrt #(.RadBits(RadBits)) u_sqrt (
    .clk      (clk),
    .rst      (rst),
    .start    (sq_go),
    .radicand (sq_x + sq_y),
    .done     (sqrt_done),
    .root     (root)
  );

  always_comb begin
    cost     = CostBits'(root) + CostBits'(penalty);
    improve  = cost < best_cost;
    new_best = improve ? cost : best_cost;
    win_now  = in_window || (cost < CostBits'(search_window_mm));
    leave    = win_now && (cost > CostBits'(search_window_mm));
  end

  always_comb begin
    state_next = state;
    take = 1'b0;
    unique case (state)
      BK_IDLE: begin
        if (job_valid && !(job_last && out_full)) begin
          take = 1'b1;
          if (!job_start && !job_last && !closed) begin
            state_next = BK_SQRT;
          end
        end
      end
      BK_SQRT: begin
        if (sqrt_done) begin
          state_next = BK_DECIDE;
        end
      end
      BK_DECIDE: begin
        if (!(leave && new_best < CostBits'(accept_limit_mm) && out_full)) begin
          state_next = BK_IDLE;
        end
      end
      default: state_next = BK_IDLE;
    endcase
  end

  assign job_take = take;
  assign empty = !out_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= BK_IDLE;
      out_full  <= 1'b0;
      mul_go    <= 1'b0;
      sq_go     <= 1'b0;
      closed    <= 1'b0;
      in_window <= 1'b0;
      best_cost <= '1;
      best_distance <= '1;
      best_index <= '0;
    end else begin
      state  <= state_next;
      mul_go <= (state == BK_IDLE) && (state_next == BK_SQRT);
      sq_go  <= mul_go;
      if (pop && out_full) begin
        out_full <= 1'b0;
      end
      if (state == BK_IDLE && take) begin
        if (job_start) begin
          best_cost     <= '1;
          best_distance <= '1;
          best_index    <= '0;
          in_window     <= 1'b0;
          closed        <= 1'b0;
        end else if (job_last) begin
          if (!closed) begin
            out_full     <= 1'b1;
            found        <= best_cost < CostBits'(accept_limit_mm);
            match_index  <= (best_cost < CostBits'(accept_limit_mm)) ? best_index : '0;
            min_distance <= best_distance;
          end
          closed <= 1'b1;
        end else if (!closed) begin
          sq_x    <= (2*CoordBits+2)'(job_ax) * (2*CoordBits+2)'(job_ax);
          sq_y    <= (2*CoordBits+2)'(job_ay) * (2*CoordBits+2)'(job_ay);
          penalty <= job_penalty;
          index   <= job_index;
        end
      end
      if (state == BK_DECIDE && state_next == BK_IDLE) begin
        if (improve) begin
          best_cost     <= cost;
          best_distance <= DistBits'(root);
          best_index    <= index;
        end
        if (leave && new_best > CostBits'(accept_limit_mm)) begin
          in_window <= 1'b0;
        end else begin
          in_window <= win_now;
        end
        if (leave && new_best < CostBits'(accept_limit_mm)) begin
          out_full     <= 1'b1;
          found        <= 1'b1;
          match_index  <= improve ? index : best_index;
          min_distance <= improve ? DistBits'(root) : best_distance;
          closed       <= 1'b1;
        end
      end
    end
  end

endmodule

// ----- design/heading_weighted_path_point_match.sv -----
// Top level of the heading-weighted path point matcher.
// Each path point at or after the start index runs in the back part through the squaring,
// the bit-serial square root that resolves one root bit per cycle, and a decide step; the
// front part accepts the next item while it runs, one item held in between. Points before
// the start index, other than a last point, and points with no search open make no job. A
// result waits in an output register until popped, and a point that closes the search early
// holds the back part until that register is free.
module heading_weighted_path_point_match import hwppm_pkg::*; #(
  parameter int unsigned INDEX_BITS = 16,
  parameter int unsigned COORD_BITS = 30
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          push,
  output logic                          full,
  input  logic                          action,
  input  logic signed [COORD_BITS-1:0]  car_x,
  input  logic signed [COORD_BITS-1:0]  car_y,
  input  logic signed [HeadingBits-1:0] car_heading,
  input  logic [INDEX_BITS-1:0]         start_hint,
  input  logic                          restart_from_zero,
  input  logic signed [COORD_BITS-1:0]  point_x,
  input  logic signed [COORD_BITS-1:0]  point_y,
  input  logic [PointHeadingBits-1:0]   point_heading,
  input  logic [INDEX_BITS-1:0]         point_index,
  input  logic                          last_point,
  output logic                          empty,
  input  logic                          pop,
  output logic                          found,
  output logic [INDEX_BITS-1:0]         match_index,
  output logic [DistBits-1:0]           min_distance,
  input  logic                          cfg_we,
  input  logic [CfgAddrBits-1:0]        cfg_addr,
  input  logic [CfgDataBits-1:0]        cfg_data
);

  logic [WindowBits-1:0]   search_window_mm;
  logic [WindowBits-1:0]   accept_limit_mm;
  logic [BackBits-1:0]     back_points;
  logic                    job_take;
  logic                    job_valid;
  logic                    job_start;
  logic                    job_last;
  logic [COORD_BITS:0]     job_ax;
  logic [COORD_BITS:0]     job_ay;
  logic [PenaltyBits-1:0]  job_penalty;
  logic [INDEX_BITS-1:0]   job_index;

  always_ff @(posedge clk) begin
    if (rst) begin
      search_window_mm <= WindowBits'(15000);
      accept_limit_mm  <= WindowBits'(10000);
      back_points      <= BackBits'(100);
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_SEARCH_WINDOW: search_window_mm <= cfg_data;
        REG_ACCEPT_LIMIT:  accept_limit_mm <= cfg_data;
        REG_BACK_POINTS:   back_points <= cfg_data[BackBits-1:0];
        default: ;
      endcase
    end
  end

  hwppm_front #(.IndexBits(INDEX_BITS), .CoordBits(COORD_BITS)) u_front (
    .clk (clk), .rst (rst), .push (push), .full (full), .action (action),
    .car_x (car_x), .car_y (car_y), .car_heading (car_heading),
    .start_hint (start_hint), .restart_from_zero (restart_from_zero),
    .point_x (point_x), .point_y (point_y), .point_heading (point_heading),
    .point_index (point_index), .last_point (last_point),
    .back_points (back_points), .job_take (job_take), .job_valid (job_valid),
    .job_start (job_start), .job_last (job_last), .job_ax (job_ax),
    .job_ay (job_ay), .job_penalty (job_penalty), .job_index (job_index)
  );

  hwppm_back #(.IndexBits(INDEX_BITS), .CoordBits(COORD_BITS)) u_back (
    .clk (clk), .rst (rst), .job_valid (job_valid), .job_take (job_take),
    .job_start (job_start), .job_last (job_last), .job_ax (job_ax),
    .job_ay (job_ay), .job_penalty (job_penalty), .job_index (job_index),
    .search_window_mm (search_window_mm), .accept_limit_mm (accept_limit_mm),
    .pop (pop), .empty (empty), .found (found), .match_index (match_index),
    .min_distance (min_distance)
  );

  a_not_found_zero: assert property (@(posedge clk) disable iff (rst)
    (!empty && !found) |-> (match_index == '0))
    else $error("match index not zero without a match");
  a_take_needs_job: assert property (@(posedge clk) disable iff (rst)
    job_take |-> job_valid)
    else $error("job taken while none held");
  a_result_held: assert property (@(posedge clk) disable iff (rst)
    ($past(!empty) && !$past(pop)) |-> (!empty && $stable(match_index)))
    else $error("waiting result changed");

endmodule
